// ===== design/scp_pkg.sv =====
package scp_pkg;

  // default result precision
  localparam int OUT_FRAC_BITS_DEF = 15;

  // width of the signed polynomial accumulators (q.30)
  localparam int PS_W = 33;

  // range reduction, degrees q16.16
  localparam logic [31:0] DEG_TURN  = 32'd23592960;   // 360 degrees
  localparam logic [31:0] DEG_HALF  = 32'd11796480;   // 180 degrees
  localparam logic [15:0] TURN_INT  = 16'd360;
  localparam logic [15:0] RECIP_360 = 16'd46603;      // floor(2^24 / 360)
  localparam int          RECIP_360_SH = 24;

  // degrees to radians: pi*2^32 = 180*RAD_Q + 105, and 105/180 = 7/12
  localparam logic [26:0] RAD_Q     = 27'd74961320;
  localparam logic [24:0] RECIP_3   = 25'd22369621;   // floor(2^26 / 3)
  localparam int          RECIP_3_SH = 26;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic signed [PS_W-1:0] QONE = PS_W'(64'sd1073741824);

  // highest-order coefficients, loaded into the first horner stage
  localparam logic signed [PS_W-1:0] SIN_TOP = -PS_W'(64'sd26);
  localparam logic signed [PS_W-1:0] COS_TOP = -PS_W'(64'sd280);

  localparam int N_STEPS = 5;

  // coefficients added by each horner step, in evaluation order
  localparam logic signed [PS_W-1:0] SIN_COEF [N_STEPS] = '{
    PS_W'(64'sd2956),
    -PS_W'(64'sd213040),
    PS_W'(64'sd8947846),
    -PS_W'(64'sd178956974),
    QONE
  };

  localparam logic signed [PS_W-1:0] COS_COEF [N_STEPS] = '{
    PS_W'(64'sd26586),
    -PS_W'(64'sd1491253),
    PS_W'(64'sd44739212),
    -PS_W'(64'sd536870912),
    QONE
  };

  // payload of the polynomial stages
  typedef struct packed {
    logic signed [PS_W-1:0] ps;
    logic signed [PS_W-1:0] pc;
    logic [31:0]            y2;
    logic [30:0]            m;
    logic                   yneg;
    logic                   flip;
  } scp_poly_t;

  // q.30 product, rounded half away from zero; b given as sign and magnitude
  function automatic logic signed [PS_W-1:0] mulq(input logic signed [PS_W-1:0] a,
                                                  input logic [31:0] b_mag,
                                                  input logic b_neg);
    logic              a_neg;
    logic [PS_W-1:0]   a_mag;
    logic [PS_W+31:0]  p;
    logic [PS_W+31:0]  r;
    logic [PS_W-1:0]   rm;
    a_neg = a[PS_W-1];
    a_mag = a_neg ? $unsigned(-a) : $unsigned(a);
    p     = (PS_W+32)'(a_mag) * (PS_W+32)'(b_mag);
    r     = (p + (PS_W+32)'(64'd536870912)) >> 30;
    rm    = r[PS_W-1:0];
    return (a_neg ^ b_neg) ? -$signed(rm) : $signed(rm);
  endfunction

endpackage

// ===== design/scp_if.sv =====
interface scp_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_degrees;

  modport source (output valid, output angle_degrees, input ready);
  modport sink   (input valid, input angle_degrees, output ready);
endinterface

interface scp_result_if #(
  parameter int OUT_W = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// ===== design/scp_horner_step.sv =====
module scp_horner_step #(
  parameter logic signed [scp_pkg::PS_W-1:0] SIN_C = '0,
  parameter logic signed [scp_pkg::PS_W-1:0] COS_C = '0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  scp_pkg::scp_poly_t  d_i,
  output scp_pkg::scp_poly_t  q_o
);
  import scp_pkg::*;

  scp_poly_t step_d, step_q;

  // one horner step of each polynomial: p = p*y^2 + c
  always_comb begin
    step_d    = d_i;
    step_d.ps = mulq(d_i.ps, d_i.y2, 1'b0) + SIN_C;
    step_d.pc = mulq(d_i.pc, d_i.y2, 1'b0) + COS_C;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

// ===== design/sine_cosine_polynomial.sv =====
// channel   | dir | modport | payload
// angle_i   | in  | sink    | angle_degrees, signed q16.16 degrees
// result_o  | out | source  | sine, cosine, signed q1.(OUT_FRAC_BITS)
//
// one angle per cycle unless an output stall backs up the pipeline
// the depth is set by the reduction divisions (reciprocal multiply, then
// correct) and the six chained q.30 multiplies of the horner evaluation
// rst_ni clears only the stage valid bits, the payload is never reset
// a stage holds when it is full and the stage after it holds; empty stages
// keep filling, so bubbles close up during an output stall
module sine_cosine_polynomial #(
  parameter int OUT_FRAC_BITS = scp_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  scp_angle_if.sink       angle_i,
  scp_result_if.source    result_o
);
  import scp_pkg::*;

  localparam int OUT_W = OUT_FRAC_BITS + 1;
  localparam int SH    = 30 - OUT_FRAC_BITS;
  localparam int NST   = 17;

  // output rounding and clamp limits
  localparam logic [PS_W:0] RND     = (SH > 0) ? (PS_W+1)'(64'd1 << (SH - 1)) : '0;
  localparam logic [PS_W:0] SAT_POS = (PS_W+1)'((64'd1 << OUT_FRAC_BITS) - 64'd1);
  localparam logic [PS_W:0] SAT_NEG = (PS_W+1)'(64'd1 << OUT_FRAC_BITS);

  // q.30 to output format, rounded half away from zero and saturated
  function automatic logic [OUT_W-1:0] to_out(input logic signed [PS_W-1:0] v);
    logic            neg;
    logic [PS_W-1:0] mag;
    logic [PS_W:0]   mr;
    logic [OUT_W-1:0] res;
    neg = v[PS_W-1];
    mag = neg ? $unsigned(-v) : $unsigned(v);
    mr  = ({1'b0, mag} + RND) >> SH;
    if (!neg && (mr > SAT_POS)) begin
      res = SAT_POS[OUT_W-1:0];
    end else if (neg && (mr > SAT_NEG)) begin
      res = SAT_NEG[OUT_W-1:0];
    end else if (neg) begin
      res = OUT_W'(-mr[OUT_W-1:0]);
    end else begin
      res = mr[OUT_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // flow control: stage k loads when it is empty or stage k+1 loads too
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = result_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= angle_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign angle_i.ready  = en[0];
  assign result_o.valid = vld_q[NST-1];

  // ---------------------------------------------------------------------------
  // stage 0: magnitude of the angle and the rounding offset of half a turn
  // ---------------------------------------------------------------------------
  logic        s0_xneg_d, s0_xneg_q;
  logic [31:0] s0_xabs_d, s0_xabs_q;
  logic [15:0] s0_v16_d,  s0_v16_q;
  logic [31:0] s0_vsum;

  always_comb begin
    s0_xneg_d = angle_i.angle_degrees[31];
    s0_xabs_d = s0_xneg_d ? (~$unsigned(angle_i.angle_degrees) + 32'd1)
                          : $unsigned(angle_i.angle_degrees);
    // the turn is 360 * 2^16, so the low 16 bits drop out of the quotient
    s0_vsum   = s0_xabs_d + DEG_HALF;
    s0_v16_d  = s0_vsum[31:16];
  end

  // ---------------------------------------------------------------------------
  // stage 1: turn count estimate by reciprocal of 360, low by at most one
  // ---------------------------------------------------------------------------
  logic        s1_xneg_q;
  logic [31:0] s1_xabs_q;
  logic [15:0] s1_v16_q;
  logic [6:0]  s1_q0_d, s1_q0_q;
  logic [31:0] s1_prod;

  always_comb begin
    s1_prod = 32'(s0_v16_q) * 32'(RECIP_360);
    s1_q0_d = s1_prod[RECIP_360_SH+6:RECIP_360_SH];
  end

  // ---------------------------------------------------------------------------
  // stage 2: correct the turn count
  // ---------------------------------------------------------------------------
  logic        s2_xneg_q;
  logic [31:0] s2_xabs_q;
  logic [6:0]  s2_q_d, s2_q_q;
  logic [15:0] s2_rem;

  always_comb begin
    s2_rem = s1_v16_q - 16'(s1_q0_q * TURN_INT);
    s2_q_d = s1_q0_q + 7'(s2_rem >= TURN_INT);
  end

  // ---------------------------------------------------------------------------
  // stage 3: remainder in degrees, as sign and magnitude (at most 180 deg)
  // ---------------------------------------------------------------------------
  logic        s3_rneg_d, s3_rneg_q;
  logic [23:0] s3_rabs_d, s3_rabs_q;
  logic [31:0] s3_qt;
  logic signed [32:0] s3_rm;
  logic [32:0] s3_rm_abs;

  always_comb begin
    s3_qt     = 32'(s2_q_q) * DEG_TURN;
    s3_rm     = $signed({1'b0, s2_xabs_q}) - $signed({1'b0, s3_qt});
    s3_rneg_d = s2_xneg_q ^ s3_rm[32];
    s3_rm_abs = s3_rm[32] ? $unsigned(-s3_rm) : $unsigned(s3_rm);
    s3_rabs_d = s3_rm_abs[23:0];
  end

  // ---------------------------------------------------------------------------
  // stage 4: r*pi/180 split as r*RAD_Q + floor(7r/12); start both parts
  // ---------------------------------------------------------------------------
  logic        s4_rneg_q;
  logic [50:0] s4_prodq_d, s4_prodq_q;
  logic [24:0] s4_n_d, s4_n_q;
  logic [26:0] s4_r7;

  always_comb begin
    s4_prodq_d = 51'(s3_rabs_q) * 51'(RAD_Q);
    s4_r7      = 27'(s3_rabs_q) * 27'd7;
    s4_n_d     = s4_r7[26:2];
  end

  // ---------------------------------------------------------------------------
  // stage 5: divide by three, estimate
  // ---------------------------------------------------------------------------
  logic        s5_rneg_q;
  logic [50:0] s5_prodq_q;
  logic [24:0] s5_n_q;
  logic [23:0] s5_d0_d, s5_d0_q;
  logic [49:0] s5_prod;

  always_comb begin
    s5_prod = 50'(s4_n_q) * 50'(RECIP_3);
    s5_d0_d = s5_prod[RECIP_3_SH+23:RECIP_3_SH];
  end

  // ---------------------------------------------------------------------------
  // stage 6: divide by three, correction
  // ---------------------------------------------------------------------------
  logic        s6_rneg_q;
  logic [50:0] s6_prodq_q;
  logic [23:0] s6_d_d, s6_d_q;
  logic [24:0] s6_rem;

  always_comb begin
    s6_rem = s5_n_q - 25'(s5_d0_q * 25'd3);
    s6_d_d = s5_d0_q + 24'(s6_rem >= 25'd3);
  end

  // ---------------------------------------------------------------------------
  // stage 7: radians with 30 fraction bits, rounded half away from zero
  // ---------------------------------------------------------------------------
  logic        s7_yneg_q;
  logic [31:0] s7_ym_d, s7_ym_q;
  logic [50:0] s7_sum;

  always_comb begin
    s7_sum  = s6_prodq_q + 51'(64'd131072) + 51'(s6_d_q);
    s7_ym_d = s7_sum[49:18];
  end

  // ---------------------------------------------------------------------------
  // stage 8: fold into [-pi/2, pi/2]; a fold negates the cosine
  // ---------------------------------------------------------------------------
  logic        s8_yneg_q;
  logic        s8_flip_d, s8_flip_q;
  logic [30:0] s8_m_d, s8_m_q;
  logic [31:0] s8_mf;

  always_comb begin
    s8_flip_d = s7_ym_q > HALF_PI_Q30;
    s8_mf     = s8_flip_d ? (PI_Q30 - s7_ym_q) : s7_ym_q;
    s8_m_d    = s8_mf[30:0];
  end

  // ---------------------------------------------------------------------------
  // stage 9: y^2 and the top coefficients
  // ---------------------------------------------------------------------------
  scp_poly_t   poly [N_STEPS+1];
  scp_poly_t   s9_d, s9_q;
  logic [61:0] s9_sq;

  always_comb begin
    s9_sq     = 62'(s8_m_q) * 62'(s8_m_q) + 62'(64'd536870912);
    s9_d.y2   = s9_sq[61:30];
    s9_d.m    = s8_m_q;
    s9_d.yneg = s8_yneg_q;
    s9_d.flip = s8_flip_q;
    s9_d.ps   = SIN_TOP;
    s9_d.pc   = COS_TOP;
  end

  assign poly[0] = s9_q;

  // ---------------------------------------------------------------------------
  // stages 10 to 14: horner steps
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < N_STEPS; i++) begin : g_horner
    scp_horner_step #(
      .SIN_C (SIN_COEF[i]),
      .COS_C (COS_COEF[i])
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en[10+i]),
      .d_i   (poly[i]),
      .q_o   (poly[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 15: final sine multiply by y, cosine sign
  // ---------------------------------------------------------------------------
  logic signed [PS_W-1:0] s15_s_d, s15_s_q;
  logic signed [PS_W-1:0] s15_c_d, s15_c_q;

  always_comb begin
    s15_s_d = mulq(poly[N_STEPS].ps, {1'b0, poly[N_STEPS].m}, poly[N_STEPS].yneg);
    s15_c_d = poly[N_STEPS].flip ? -poly[N_STEPS].pc : poly[N_STEPS].pc;
  end

  // ---------------------------------------------------------------------------
  // stage 16: output register, rounded and saturated
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] s16_sin_d, s16_sin_q;
  logic [OUT_W-1:0] s16_cos_d, s16_cos_q;

  always_comb begin
    s16_sin_d = to_out(s15_s_q);
    s16_cos_d = to_out(s15_c_q);
  end

  assign result_o.sine   = $signed(s16_sin_q);
  assign result_o.cosine = $signed(s16_cos_q);

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_xneg_q <= s0_xneg_d;
      s0_xabs_q <= s0_xabs_d;
      s0_v16_q  <= s0_v16_d;
    end
    if (en[1]) begin
      s1_xneg_q <= s0_xneg_q;
      s1_xabs_q <= s0_xabs_q;
      s1_v16_q  <= s0_v16_q;
      s1_q0_q   <= s1_q0_d;
    end
    if (en[2]) begin
      s2_xneg_q <= s1_xneg_q;
      s2_xabs_q <= s1_xabs_q;
      s2_q_q    <= s2_q_d;
    end
    if (en[3]) begin
      s3_rneg_q <= s3_rneg_d;
      s3_rabs_q <= s3_rabs_d;
    end
    if (en[4]) begin
      s4_rneg_q  <= s3_rneg_q;
      s4_prodq_q <= s4_prodq_d;
      s4_n_q     <= s4_n_d;
    end
    if (en[5]) begin
      s5_rneg_q  <= s4_rneg_q;
      s5_prodq_q <= s4_prodq_q;
      s5_n_q     <= s4_n_q;
      s5_d0_q    <= s5_d0_d;
    end
    if (en[6]) begin
      s6_rneg_q  <= s5_rneg_q;
      s6_prodq_q <= s5_prodq_q;
      s6_d_q     <= s6_d_d;
    end
    if (en[7]) begin
      s7_yneg_q <= s6_rneg_q;
      s7_ym_q   <= s7_ym_d;
    end
    if (en[8]) begin
      s8_yneg_q <= s7_yneg_q;
      s8_flip_q <= s8_flip_d;
      s8_m_q    <= s8_m_d;
    end
    if (en[9]) begin
      s9_q <= s9_d;
    end
    if (en[15]) begin
      s15_s_q <= s15_s_d;
      s15_c_q <= s15_c_d;
    end
    if (en[16]) begin
      s16_sin_q <= s16_sin_d;
      s16_cos_q <= s16_cos_d;
    end
  end

endmodule

// ===== tb/sine_cosine_polynomial_test.sv =====
module sine_cosine_polynomial_test;
  timeunit 1ns;
  timeprecision 1ps;

  // result precision and width follow the block's default
  localparam int OFB   = scp_pkg::OUT_FRAC_BITS_DEF;
  localparam int OUT_W = OFB + 1;

  // one degree in q16.16
  localparam int DEG = 65536;

  typedef logic signed [OUT_W-1:0] sample_t;
  typedef longint unsigned u64_t;

  // one expected result, with its angle kept for the mismatch report
  typedef struct packed {
    logic signed [31:0] angle;
    sample_t            sine;
    sample_t            cosine;
  } trig_t;

  // a directed row: the angle, and the answer when it is obvious
  typedef struct packed {
    logic signed [31:0] angle;
    logic               known;
    sample_t            sine;
    sample_t            cosine;
  } probe_t;

  // ways the result side takes requests
  typedef enum int {
    DRAIN_FULL,
    DRAIN_COIN,
    DRAIN_BEAT,
    DRAIN_SPARSE
  } drain_mode_e;

  // range reduction and radian conversion constants
  localparam longint TURN_DEG   = 64'sd23592960;     // 360 degrees, q16.16
  localparam u64_t   TURN_ROUND = 64'd11796480;      // half a turn, for rounding
  localparam u64_t   TURN_U     = 64'd23592960;
  localparam u64_t   PI_SCALED  = 64'd13493037705;   // pi * 2^32
  localparam u64_t   RAD_DEN    = 64'd47185920;      // 180 * 2^18
  localparam u64_t   RAD_ROUND  = 64'd23592960;
  localparam longint PI_RAD     = 64'sd3373259426;   // pi, q.30
  localparam longint HALF_PI    = 64'sd1686629713;   // pi/2, q.30
  localparam longint ONE_Q30    = 64'sd1073741824;

  // output rounding and clamp bounds
  localparam int     ROUND_SH   = 30 - OFB;
  localparam longint SAMPLE_MAX = (longint'(1) << OFB) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << OFB);
  localparam sample_t SAT_HI    = sample_t'(SAMPLE_MAX);
  localparam sample_t ZERO      = sample_t'(0);

  localparam int RANDOM_ITEMS  = 1880;
  localparam int IDLE_AT       = 900;   // random item before which the sender waits for idle
  localparam int HOLD_AFTER    = 300;   // results seen before the long receiver stall
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 40;    // well past the pipeline latency

  logic clk_i;
  logic rst_ni;

  scp_angle_if                  angle_if ();
  scp_result_if #(.OUT_W(OUT_W)) result_if ();

  sine_cosine_polynomial #(
    .OUT_FRAC_BITS(OFB)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .angle_i  (angle_if),
    .result_o (result_if)
  );

  // expected sine/cosine pairs, oldest first
  trig_t pending_trig [$];

  int faults;
  int results_seen;
  int burst_left;
  bit holdoff_done;

  // answer that goes with the angle on the bus, when the row gives one
  bit      typed_known;
  sample_t typed_sine;
  sample_t typed_cosine;

  // directed angles: turn multiples, the half-way quotient on both signs,
  // fold thresholds around +-90 degrees, the edges of +-180 and the input extremes
  probe_t probes [24] = '{
    '{32'(0),             1'b1, ZERO, SAT_HI},
    '{32'(360 * DEG),     1'b1, ZERO, SAT_HI},
    '{32'(-360 * DEG),    1'b1, ZERO, SAT_HI},
    '{32'(720 * DEG),     1'b1, ZERO, SAT_HI},
    '{32'(180 * DEG),     1'b0, ZERO, ZERO},
    '{32'(-180 * DEG),    1'b0, ZERO, ZERO},
    '{32'(540 * DEG),     1'b0, ZERO, ZERO},
    '{32'(-540 * DEG),    1'b0, ZERO, ZERO},
    '{32'(1980 * DEG),    1'b0, ZERO, ZERO},
    '{32'(-1980 * DEG),   1'b0, ZERO, ZERO},
    '{32'(90 * DEG),      1'b0, ZERO, ZERO},
    '{32'(90 * DEG + 1),  1'b0, ZERO, ZERO},
    '{32'(90 * DEG - 1),  1'b0, ZERO, ZERO},
    '{32'(-90 * DEG),     1'b0, ZERO, ZERO},
    '{32'(-90 * DEG - 1), 1'b0, ZERO, ZERO},
    '{32'(270 * DEG),     1'b0, ZERO, ZERO},
    '{32'(-270 * DEG),    1'b0, ZERO, ZERO},
    '{32'(45 * DEG),      1'b0, ZERO, ZERO},
    '{32'(1),             1'b0, ZERO, ZERO},
    '{32'(-1),            1'b0, ZERO, ZERO},
    '{32'(180 * DEG - 1), 1'b0, ZERO, ZERO},
    '{32'(-180 * DEG + 1), 1'b0, ZERO, ZERO},
    '{32'h7FFF_FFFF,      1'b0, ZERO, ZERO},
    '{32'h8000_0000,      1'b0, ZERO, ZERO}
  };

  function automatic u64_t magnitude(input longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic longint signed_of(input bit neg, input u64_t m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // q.30 product, rounded half away from zero
  function automatic longint qmul(input longint a, input longint b);
    u64_t p;
    p = magnitude(a) * magnitude(b);
    p = (p + (64'd1 << 29)) >> 30;
    return signed_of((a < 0) != (b < 0), p);
  endfunction

  // q.30 down to the output precision, rounded half away from zero, then clamped
  function automatic sample_t to_sample(input longint v);
    u64_t   m;
    longint r;
    m = magnitude(v);
    if (ROUND_SH > 0) m = (m + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    r = signed_of(v < 0, m);
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    return sample_t'(r);
  endfunction

  // sine and cosine of a q16.16 angle in degrees, bit exact
  function automatic trig_t predict_sincos(input logic signed [31:0] a);
    longint x, turns, rem, y, y2, ps, pc, s, c;
    bit     flip;
    trig_t  t;
    x = longint'(a);
    // nearest whole turn, a half-way quotient goes away from zero
    turns = signed_of(x < 0, (magnitude(x) + TURN_ROUND) / TURN_U);
    rem   = x - turns * TURN_DEG;
    // degrees to radians with 30 fraction bits
    y = signed_of(rem < 0, (magnitude(rem) * PI_SCALED + RAD_ROUND) / RAD_DEN);
    // fold into [-pi/2, pi/2]; a fold negates the cosine
    flip = 1'b0;
    if (y > HALF_PI) begin
      y    = PI_RAD - y;
      flip = 1'b1;
    end else if (y < -HALF_PI) begin
      y    = -PI_RAD - y;
      flip = 1'b1;
    end
    y2 = qmul(y, y);
    // odd sine series in horner form
    ps = -64'sd26;
    ps = qmul(ps, y2) + 64'sd2956;
    ps = qmul(ps, y2) - 64'sd213040;
    ps = qmul(ps, y2) + 64'sd8947846;
    ps = qmul(ps, y2) - 64'sd178956974;
    ps = qmul(ps, y2) + ONE_Q30;
    s  = qmul(ps, y);
    // even cosine series in horner form
    pc = -64'sd280;
    pc = qmul(pc, y2) + 64'sd26586;
    pc = qmul(pc, y2) - 64'sd1491253;
    pc = qmul(pc, y2) + 64'sd44739212;
    pc = qmul(pc, y2) - 64'sd536870912;
    pc = qmul(pc, y2) + ONE_Q30;
    c  = flip ? -pc : pc;
    t.angle  = a;
    t.sine   = to_sample(s);
    t.cosine = to_sample(c);
    return t;
  endfunction

  // put one angle on the bus, hold it until taken, then maybe leave a gap
  task automatic offer_angle(input logic signed [31:0] a, input bit known,
                             input sample_t s, input sample_t c);
    int gap;
    @(negedge clk_i);
    angle_if.valid         <= 1'b1;
    angle_if.angle_degrees <= a;
    typed_known  = known;
    typed_sine   = s;
    typed_cosine = c;
    @(posedge clk_i);
    while (!angle_if.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // new burst; a quarter of the bursts follow on with no gap at all
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk_i);
        angle_if.valid <= 1'b0;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  // one check point per edge: results first, then new requests
  always @(posedge clk_i) begin
    trig_t want;
    trig_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (pending_trig.size() == 0) begin
        faults++;
        $display("%0t unexpected result sine %0d cosine %0d", $realtime,
                 result_if.sine, result_if.cosine);
      end else begin
        want = pending_trig.pop_front();
        if (result_if.sine !== want.sine) begin
          faults++;
          $display("%0t angle %h sine expected %0d actual %0d", $realtime,
                   want.angle, want.sine, result_if.sine);
        end
        if (result_if.cosine !== want.cosine) begin
          faults++;
          $display("%0t angle %h cosine expected %0d actual %0d", $realtime,
                   want.angle, want.cosine, result_if.cosine);
        end
      end
    end
    if (rst_ni && angle_if.valid && angle_if.ready) begin
      if (typed_known) begin
        got.angle  = angle_if.angle_degrees;
        got.sine   = typed_sine;
        got.cosine = typed_cosine;
      end else begin
        got = predict_sincos(angle_if.angle_degrees);
      end
      pending_trig.push_back(got);
    end
  end

  // result side: phases of random length, each with its own ready pattern,
  // and once a long stall so the pipeline fills and backs up the input
  initial begin : result_drain
    drain_mode_e mode;
    int          span;
    int          k;
    result_if.ready = 1'b0;
    forever begin
      mode = drain_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (!holdoff_done && results_seen >= HOLD_AFTER) begin
          holdoff_done = 1'b1;
          result_if.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        end else begin
          case (mode)
            DRAIN_FULL:   result_if.ready <= 1'b1;
            DRAIN_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
            DRAIN_BEAT:   result_if.ready <= ((k % 4) != 3);
            DRAIN_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
            default:      result_if.ready <= 1'b1;
          endcase
        end
      end
    end
  end

  // reset, directed table, random angles, then drain and report
  initial begin : stimulus
    logic signed [31:0] a;
    int                 n;
    int                 k;
    rst_ni                 = 1'b0;
    angle_if.valid         = 1'b0;
    angle_if.angle_degrees = '0;
    typed_known            = 1'b0;
    typed_sine             = '0;
    typed_cosine           = '0;
    faults                 = 0;
    results_seen           = 0;
    burst_left             = 0;
    holdoff_done           = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probes[i])
      offer_angle(probes[i].angle, probes[i].known, probes[i].sine, probes[i].cosine);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == IDLE_AT) begin
        // let the whole pipeline run dry once
        @(negedge clk_i);
        angle_if.valid <= 1'b0;
        while (pending_trig.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: a = $urandom;
        // within a little more than one turn either way
        4, 5, 6: a = int'($urandom_range(0, 800 * DEG)) - 400 * DEG;
        // a few lsbs around multiples of 90 degrees: folds and half-way quotients
        7, 8: begin
          k = int'($urandom_range(0, 80)) - 40;
          a = k * 90 * DEG + int'($urandom_range(0, 8)) - 4;
        end
        // close to the ends of the input range
        default: a = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 4095)
                                         : 32'h8000_0000 + $urandom_range(0, 4095);
      endcase
      offer_angle(a, 1'b0, ZERO, ZERO);
    end

    @(negedge clk_i);
    angle_if.valid <= 1'b0;
    while (pending_trig.size() != 0) @(posedge clk_i);
    // stray results after the last one would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (faults == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
